// File: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg - shared types and codes of the stable priority queue
// Entry layout, operation and status codes, sequencer states and the
// structs that pass between the queue's modules.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int PRI_W  = 3;
   localparam int VEH_W  = 64;
   localparam int TIME_W = 32;
   localparam int OCC_W  = 5;
   localparam int STAT_W = 2;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [PRI_W-1:0]  pri;
      logic [VEH_W-1:0]  vehicle;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic      wr_en;
      entry_type wr_data;
   } store_wr_type;

   typedef struct packed {
      logic              valid;
      logic [STAT_W-1:0] status;
      entry_type         entry;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH_SCAN,
      ST_PLACE_FRONT,
      ST_POP_HEAD,
      ST_POP_SHIFT,
      ST_RESULT
   } seq_state_type;

endpackage

// File: design/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue - bounded sorted priority queue, stable on ties
// Push inserts by priority (lower first, equal in arrival order); pop
// returns the front entry. Full pushes and empty pops are flagged.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req_     in         req_valid / req_ready  kind, priority, vehicle, time tags
//  rsp_     out        rsp_valid / rsp_ready  status, popped entry, occupancy
//
//  the single store read port and its registered read data set the walk to one
//  slot a cycle. a flagged push or pop goes straight to its result.
//  reset clears the sequencer, entry count and response valid; the store
//  itself is not cleared.
//  a held response does not block the next request, but the following
//  result waits until the held one is transferred.
// ----------------------------------------------------------------------------
module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [PRI_W-1:0]  req_priority_req,
   input  logic [VEH_W-1:0]  req_vehicle_tag,
   input  logic [TIME_W-1:0] req_time_tag,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [PRI_W-1:0]  rsp_out_priority,
   output logic [VEH_W-1:0]  rsp_out_vehicle,
   output logic [TIME_W-1:0] rsp_out_time,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   entry_type        req_entry;
   result_type       result;
   logic [CNT_W-1:0] count;
   logic             slot_free;
   store_wr_type     store_wr;
   logic [IDX_W-1:0] store_wr_addr;
   logic [IDX_W-1:0] store_rd_addr;
   entry_type        store_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   entry_type         rsp_entry_ff, rsp_entry_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;

   assign req_entry.pri     = req_priority_req;
   assign req_entry.vehicle = req_vehicle_tag;
   assign req_entry.stamp   = req_time_tag;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   spq_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_entry     (req_entry),
      .slot_free     (slot_free),
      .result        (result),
      .count         (count),
      .store_wr      (store_wr),
      .store_wr_addr (store_wr_addr),
      .store_rd_addr (store_rd_addr),
      .store_rd_data (store_rd_data)
   );

   spq_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr      (store_wr),
      .wr_addr (store_wr_addr),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (result.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result.status;
         rsp_entry_in  = result.entry;
         rsp_occ_in    = OCC_W'(count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_priority = rsp_entry_ff.pri;
   assign rsp_out_vehicle  = rsp_entry_ff.vehicle;
   assign rsp_out_time     = rsp_entry_ff.stamp;
   assign rsp_occupancy    = rsp_occ_ff;

endmodule

// File: design/spq_store.sv
// ----------------------------------------------------------------------------
// spq_store - entry memory of the priority queue
// One write port and one read port; read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module spq_store
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16,
   localparam int IDX_W = $clog2(CAPACITY)
) (
   input  logic             clock,
   input  store_wr_type     wr,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem[wr_addr] <= wr.wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/spq_seq.sv
// ----------------------------------------------------------------------------
// spq_seq - insertion and removal sequencer
// Walks the sorted store one slot a cycle with a single priority
// comparator: a push shifts worse entries back until its slot is found,
// a pop takes the front entry and shifts the rest forward.
// ----------------------------------------------------------------------------
module spq_seq
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  entry_type         req_entry,
   input  logic              slot_free,
   output result_type        result,
   output logic [CNT_W-1:0]  count,
   output store_wr_type      store_wr,
   output logic [IDX_W-1:0]  store_wr_addr,
   output logic [IDX_W-1:0]  store_rd_addr,
   input  entry_type         store_rd_data
);

   seq_state_type     state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   entry_type         new_ff, new_in;
   entry_type         out_ff, out_in;
   logic [STAT_W-1:0] status_ff, status_in;

   logic             accept;
   logic             full;
   logic             empty;
   logic             worse;
   logic             at_last;
   logic [IDX_W-1:0] last_idx;

   assign accept   = req_valid && req_ready;
   assign full     = count_ff == CNT_W'(CAPACITY);
   assign empty    = count_ff == '0;
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign at_last  = idx_ff == last_idx;
   // the shared comparator: held entry strictly worse than the new one
   assign worse    = store_rd_data.pri > new_ff.pri;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_PUSH) begin
                  if (full) begin
                     state_in = ST_RESULT;
                  end else if (empty) begin
                     state_in = ST_PLACE_FRONT;
                  end else begin
                     state_in = ST_PUSH_SCAN;
                  end
               end else begin
                  state_in = empty ? ST_RESULT : ST_POP_HEAD;
               end
            end
         end
         ST_PUSH_SCAN: begin
            if (!worse) begin
               state_in = ST_RESULT;
            end else if (idx_ff == '0) begin
               state_in = ST_PLACE_FRONT;
            end
         end
         ST_PLACE_FRONT: state_in = ST_RESULT;
         ST_POP_HEAD: begin
            state_in = (count_ff == CNT_W'(1)) ? ST_RESULT : ST_POP_SHIFT;
         end
         ST_POP_SHIFT: begin
            if (at_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      idx_in        = idx_ff;
      count_in      = count_ff;
      new_in        = new_ff;
      out_in        = out_ff;
      status_in     = status_ff;
      store_wr      = '0;
      store_wr_addr = '0;
      store_rd_addr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               new_in    = req_entry;
               out_in    = '0;
               status_in = STATUS_OK;
               if (req_kind == KIND_PUSH) begin
                  if (full) begin
                     status_in = STATUS_FULL;
                  end
                  // scan from the back entry towards the front
                  idx_in        = last_idx;
                  store_rd_addr = last_idx;
               end else begin
                  if (empty) begin
                     status_in = STATUS_EMPTY;
                  end
                  idx_in        = '0;
                  store_rd_addr = '0;
               end
            end
         end
         ST_PUSH_SCAN: begin
            store_wr.wr_en = 1'b1;
            store_wr_addr  = idx_ff + IDX_W'(1);
            if (worse) begin
               store_wr.wr_data = store_rd_data;
               idx_in           = idx_ff - IDX_W'(1);
               store_rd_addr    = idx_ff - IDX_W'(1);
            end else begin
               // equal priority stays ahead, so the new entry goes behind it
               store_wr.wr_data = new_ff;
               count_in         = count_ff + CNT_W'(1);
            end
         end
         ST_PLACE_FRONT: begin
            store_wr.wr_en   = 1'b1;
            store_wr.wr_data = new_ff;
            store_wr_addr    = '0;
            count_in         = count_ff + CNT_W'(1);
         end
         ST_POP_HEAD: begin
            out_in = store_rd_data;
            if (count_ff == CNT_W'(1)) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               idx_in        = IDX_W'(1);
               store_rd_addr = IDX_W'(1);
            end
         end
         ST_POP_SHIFT: begin
            store_wr.wr_en   = 1'b1;
            store_wr.wr_data = store_rd_data;
            store_wr_addr    = idx_ff - IDX_W'(1);
            if (at_last) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               idx_in        = idx_ff + IDX_W'(1);
               store_rd_addr = idx_ff + IDX_W'(1);
            end
         end
         ST_RESULT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      new_ff    <= new_in;
      out_ff    <= out_in;
      status_ff <= status_in;
   end

   assign req_ready     = state_ff == ST_IDLE;
   assign result.valid  = (state_ff == ST_RESULT) && slot_free;
   assign result.status = status_ff;
   assign result.entry  = out_ff;
   assign count         = count_ff;

endmodule

// File: verif/spq_order_checker.sv
// ----------------------------------------------------------------------------
// spq_order_checker - result predictor and comparator for the priority queue
// Watches both channels, keeps its own sorted copy of the queue contents,
// works out the result of every accepted operation and compares each
// returned result field by field, oldest first.
// ----------------------------------------------------------------------------
module spq_order_checker
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_kind,
   input  logic [PRI_W-1:0]  req_priority_req,
   input  logic [VEH_W-1:0]  req_vehicle_tag,
   input  logic [TIME_W-1:0] req_time_tag,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [STAT_W-1:0] rsp_status,
   input  logic [PRI_W-1:0]  rsp_out_priority,
   input  logic [VEH_W-1:0]  rsp_out_vehicle,
   input  logic [TIME_W-1:0] rsp_out_time,
   input  logic [OCC_W-1:0]  rsp_occupancy,
   output int                errors,
   output int                outstanding,
   output int                results_seen,
   output int                full_drops,
   output int                empty_pops,
   output int                peak_occupancy
);

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PRI_W-1:0]  pri;
      logic [VEH_W-1:0]  vehicle;
      logic [TIME_W-1:0] stamp;
      logic [OCC_W-1:0]  occupancy;
   } queue_outcome_type;

   entry_type         held_entries[$];
   queue_outcome_type awaited_results[$];

   initial begin
      errors = 0;
      outstanding = 0;
      results_seen = 0;
      full_drops = 0;
      empty_pops = 0;
      peak_occupancy = 0;
   end

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_error($sformatf("result %0d: %s is %0h, expected %0h",
                                results_seen, name, got, want));
   endtask

   // sorted insert after every entry not worse than the new one keeps ties in order
   function automatic queue_outcome_type apply_queue_op(input logic kind,
                                                        input logic [PRI_W-1:0] pri,
                                                        input logic [VEH_W-1:0] veh,
                                                        input logic [TIME_W-1:0] tim);
      queue_outcome_type res;
      entry_type         e;
      int                pos;
      res = '0;
      if (kind == KIND_PUSH) begin
         if (held_entries.size() >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < held_entries.size() && held_entries[pos].pri <= pri)
               pos++;
            e.pri = pri;
            e.vehicle = veh;
            e.stamp = tim;
            held_entries.insert(pos, e);
            res.status = STATUS_OK;
         end
      end else begin
         if (held_entries.size() == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            e = held_entries.pop_front();
            res.status = STATUS_OK;
            res.pri = e.pri;
            res.vehicle = e.vehicle;
            res.stamp = e.stamp;
         end
      end
      res.occupancy = OCC_W'(held_entries.size());
      return res;
   endfunction

   always @(posedge clock) begin
      queue_outcome_type got;
      queue_outcome_type want;
      if (reset) begin
         held_entries.delete();
         awaited_results.delete();
         outstanding = 0;
      end else begin
         // a result can never belong to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.pri = rsp_out_priority;
            got.vehicle = rsp_out_vehicle;
            got.stamp = rsp_out_time;
            got.occupancy = rsp_occupancy;
            if (awaited_results.size() == 0) begin
               report_error("result transfer with nothing outstanding");
            end else begin
               want = awaited_results.pop_front();
               check_field("status", got.status, want.status);
               check_field("priority", got.pri, want.pri);
               check_field("vehicle", got.vehicle, want.vehicle);
               check_field("time", got.stamp, want.stamp);
               check_field("occupancy", got.occupancy, want.occupancy);
               results_seen++;
            end
         end
         if (req_valid && req_ready) begin
            want = apply_queue_op(req_kind, req_priority_req, req_vehicle_tag,
                                  req_time_tag);
            if (want.status == STATUS_FULL)
               full_drops++;
            if (want.status == STATUS_EMPTY)
               empty_pops++;
            if (int'(want.occupancy) > peak_occupancy)
               peak_occupancy = int'(want.occupancy);
            awaited_results.push_back(want);
         end
         outstanding = awaited_results.size();
      end
   end

endmodule

// File: verif/stable_priority_queue_test.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_test - randomised test of the stable priority queue
// Drives push and pop operations with directed corner cases followed by
// phased random traffic under varying sender gaps and receiver stalls;
// a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module stable_priority_queue_test
   import spq_pkg::*;
();

   localparam int CAPACITY       = 16;
   localparam int CLK_PERIOD     = 12;
   localparam int TIMEOUT_CYCLES = 800000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_kind = KIND_PUSH;
   logic [PRI_W-1:0]  req_priority_req = '0;
   logic [VEH_W-1:0]  req_vehicle_tag = '0;
   logic [TIME_W-1:0] req_time_tag = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [PRI_W-1:0]  rsp_out_priority;
   logic [VEH_W-1:0]  rsp_out_vehicle;
   logic [TIME_W-1:0] rsp_out_time;
   logic [OCC_W-1:0]  rsp_occupancy;

   int errors;
   int outstanding;
   int results_seen;
   int full_drops;
   int empty_pops;
   int peak_occupancy;

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_ask = 0;
   int hold_left = 0;

   stable_priority_queue #(.CAPACITY(CAPACITY)) dut (.*);

   spq_order_checker #(.CAPACITY(CAPACITY)) checker_inst (.*);

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("timeout with %0d results outstanding", outstanding);
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: a long hold-off when asked, otherwise random stalls
   always @(negedge clock) begin
      if (hold_ask > 0) begin
         hold_left = hold_ask;
         hold_ask = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [VEH_W-1:0] rand_vehicle();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] rand_stamp();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic offer_op(input logic kind, input logic [PRI_W-1:0] pri,
                           input logic [VEH_W-1:0] veh, input logic [TIME_W-1:0] tim);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_priority_req <= pri;
      req_vehicle_tag <= veh;
      req_time_tag <= tim;
      @(posedge clock);
      while (!(req_valid && req_ready))
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic offer_random(input int push_pct, input int pri_lo, input int pri_hi);
      logic kind;
      kind = ($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP;
      offer_op(kind, PRI_W'($urandom_range(pri_hi, pri_lo)), rand_vehicle(),
               rand_stamp());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   initial begin
      logic [PRI_W-1:0] fill_pri[16];
      int push_pct;
      int pri_lo;
      int pri_hi;
      fill_pri = '{3'd7, 3'd0, 3'd3, 3'd3, 3'd0, 3'd7, 3'd3, 3'd1,
                   3'd6, 3'd2, 3'd4, 3'd5, 3'd3, 3'd0, 3'd7, 3'd3};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty pop, fill with ties and extremes, full push, pops
      offer_op(KIND_POP, '1, '1, '1);
      offer_op(KIND_PUSH, fill_pri[0], '1, '1);
      offer_op(KIND_PUSH, fill_pri[1], '0, '0);
      for (int i = 2; i < CAPACITY; i++)
         offer_op(KIND_PUSH, fill_pri[i], {32'hA5A5_0000 + i, $urandom}, $urandom);
      offer_op(KIND_PUSH, '0, '1, '1);
      repeat (4) offer_op(KIND_POP, '0, '0, '0);
      wait_drained();

      for (int seg = 0; seg < 26; seg++) begin
         case (seg % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 86; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 86; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         case (seg % 3)
            0: push_pct = 85;
            1: push_pct = 50;
            default: push_pct = 20;
         endcase
         // narrow priority bands pile up ties
         if ($urandom_range(1) == 0) begin
            pri_lo = $urandom_range(7);
            pri_hi = (pri_lo == 7) ? 7 : pri_lo + $urandom_range(1);
         end else begin
            pri_lo = 0;
            pri_hi = 7;
         end
         if (seg == 6 || seg == 17) begin
            hold_ask = 250;
            repeat (12) offer_random(90, 0, 7);
         end
         repeat (50) offer_random(push_pct, pri_lo, pri_hi);
         if (seg % 5 == 4)
            wait_drained();
      end

      idle_pct = 0;
      stall_pct = 0;
      wait_drained();
      repeat (40) @(negedge clock);

      $display("checked %0d results: %0d pushes dropped on a full queue, %0d pops of an",
               results_seen, full_drops, empty_pops);
      $display("empty queue, occupancy reached %0d of %0d", peak_occupancy, CAPACITY);
      if (errors == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
